[rtl/ddo_pkg.sv]
`default_nettype none

package ddo_pkg;

  // CORDIC step count bounds and the index width that covers them
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int CORDIC_STEPS_MAX = 24;
  localparam int ITER_W           = 5;

  // Stream payload widths
  localparam int IN_DATA_W  = 40;
  localparam int IN_USED_W  = 38;
  localparam int OUT_DATA_W = 48;

  // Sequencer steps, shared by the controller and the datapath
  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_CORDIC,
    S_ROUND,
    S_MUL_M,
    S_MUL_K,
    S_MUL_X,
    S_MUL_Y,
    S_ABS_X,
    S_MUL_QX,
    S_MUL_QY,
    S_SAT_X,
    S_WRITE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic              load;   // latch the input transfer
    logic              write;  // commit the pose and load the output register
    state_t            step;   // current step of the sequence
    logic [ITER_W-1:0] iter;   // CORDIC micro-rotation index
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_req;           // latched item asks for a pose clear
  } status_t;

endpackage

`default_nettype wire

[rtl/ddo_ctrl.sv]
`default_nettype none

module ddo_ctrl #(
  parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  wire              out_ready,
  input  wire ddo_pkg::status_t status,
  output ddo_pkg::cmd_t    cmd
);

  localparam int NSTEPS = (CORDIC_STEPS > ddo_pkg::CORDIC_STEPS_MAX) ?
                          ddo_pkg::CORDIC_STEPS_MAX : CORDIC_STEPS;
  localparam logic [ddo_pkg::ITER_W-1:0] LAST_ITER = ddo_pkg::ITER_W'(NSTEPS - 1);

  ddo_pkg::state_t             state;
  ddo_pkg::state_t             state_next;
  logic [ddo_pkg::ITER_W-1:0]  iter;
  logic [ddo_pkg::ITER_W-1:0]  iter_next;
  logic                        load;
  logic                        write;

  // State, iteration counter and output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ddo_pkg::S_IDLE;
      iter      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      iter  <= iter_next;
      if (write) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    iter_next  = iter;
    load       = 1'b0;
    write      = 1'b0;
    in_ready   = 1'b0;
    case (state)
      ddo_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          load       = 1'b1;
          state_next = ddo_pkg::S_PREP;
        end
      end
      ddo_pkg::S_PREP: begin
        iter_next = '0;
        if (status.clear_req) begin
          state_next = ddo_pkg::S_WRITE;
        end else begin
          state_next = ddo_pkg::S_CORDIC;
        end
      end
      ddo_pkg::S_CORDIC: begin
        iter_next = iter + 1'b1;
        if (iter == LAST_ITER) begin
          state_next = ddo_pkg::S_ROUND;
        end
      end
      ddo_pkg::S_ROUND:  state_next = ddo_pkg::S_MUL_M;
      ddo_pkg::S_MUL_M:  state_next = ddo_pkg::S_MUL_K;
      ddo_pkg::S_MUL_K:  state_next = ddo_pkg::S_MUL_X;
      ddo_pkg::S_MUL_X:  state_next = ddo_pkg::S_MUL_Y;
      ddo_pkg::S_MUL_Y:  state_next = ddo_pkg::S_ABS_X;
      ddo_pkg::S_ABS_X:  state_next = ddo_pkg::S_MUL_QX;
      ddo_pkg::S_MUL_QX: state_next = ddo_pkg::S_MUL_QY;
      ddo_pkg::S_MUL_QY: state_next = ddo_pkg::S_SAT_X;
      ddo_pkg::S_SAT_X:  state_next = ddo_pkg::S_WRITE;
      ddo_pkg::S_WRITE: begin
        // hold until the output register is free
        if (!out_valid || out_ready) begin
          write      = 1'b1;
          state_next = ddo_pkg::S_IDLE;
        end
      end
      default: state_next = ddo_pkg::S_IDLE;
    endcase
  end

  assign cmd.load  = load;
  assign cmd.write = write;
  assign cmd.step  = state;
  assign cmd.iter  = iter;

endmodule

`default_nettype wire

[rtl/ddo_datapath.sv]
`default_nettype none

module ddo_datapath (
  input  wire                                clk,
  input  wire                                rst,
  input  wire ddo_pkg::cmd_t                 cmd,
  output ddo_pkg::status_t                   status,
  input  wire                                in_clear,
  input  wire  [ddo_pkg::IN_USED_W-1:0]      in_data,  // left_speed, right_speed, duration_ms
  output logic [ddo_pkg::OUT_DATA_W-1:0]     out_data  // pos_x, pos_y, heading
);

  localparam logic signed [31:0] CORDIC_X0 = 32'sd652032874;
  localparam logic signed [27:0] HEAD_K    = 28'sd3208521;
  // ceil(2^36 / 1000), exact quotient for dividends below 2^26
  localparam logic signed [27:0] RECIP     = 28'sd68719477;
  localparam int                 RECIP_SH  = 36;

  // CORDIC micro-rotation angles, 2^32 units per turn
  function automatic logic signed [31:0] atan_angle(input logic [ddo_pkg::ITER_W-1:0] i);
    logic signed [31:0] a;
    case (i)
      5'd0:  a = 32'sd536870912;
      5'd1:  a = 32'sd316933406;
      5'd2:  a = 32'sd167458907;
      5'd3:  a = 32'sd85004756;
      5'd4:  a = 32'sd42667331;
      5'd5:  a = 32'sd21354465;
      5'd6:  a = 32'sd10679838;
      5'd7:  a = 32'sd5340245;
      5'd8:  a = 32'sd2670163;
      5'd9:  a = 32'sd1335087;
      5'd10: a = 32'sd667544;
      5'd11: a = 32'sd333772;
      5'd12: a = 32'sd166886;
      5'd13: a = 32'sd83443;
      5'd14: a = 32'sd41722;
      5'd15: a = 32'sd20861;
      5'd16: a = 32'sd10430;
      5'd17: a = 32'sd5215;
      5'd18: a = 32'sd2608;
      5'd19: a = 32'sd1304;
      5'd20: a = 32'sd652;
      5'd21: a = 32'sd326;
      5'd22: a = 32'sd163;
      5'd23: a = 32'sd81;
      default: a = 32'sd0;
    endcase
    return a;
  endfunction

  // Round Q2.30 to Q1.15 (floor after half add) and saturate
  function automatic logic signed [15:0] to_q15(input logic signed [31:0] v);
    logic signed [32:0] t;
    logic signed [17:0] r;
    logic signed [15:0] q;
    t = {v[31], v} + 33'sd16384;
    r = t[32:15];
    if (r > 18'sd32767) begin
      q = 16'sd32767;
    end else if (r < -18'sd32767) begin
      q = -16'sd32767;
    end else begin
      q = r[15:0];
    end
    return q;
  endfunction

  // Apply sign to a quotient magnitude and saturate
  function automatic logic signed [15:0] sat_coord(input logic neg, input logic [16:0] mag);
    logic [14:0] m;
    m = (mag > 17'd32767) ? 15'h7FFF : mag[14:0];
    return neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
  endfunction

  // Latched item
  logic                       clear_l;
  logic signed [11:0]         left_l;
  logic signed [11:0]         right_l;
  logic [13:0]                dur_l;

  // Pose state
  logic signed [15:0]         pose_x;
  logic signed [15:0]         pose_y;
  logic [23:0]                pose_h;

  // Working registers
  logic signed [12:0]         sum;
  logic [11:0]                absdiff;
  logic                       diff_neg;
  logic signed [31:0]         cx;
  logic signed [31:0]         cy;
  logic signed [31:0]         cz;
  logic [1:0]                 quad;
  logic signed [15:0]         sn;
  logic signed [15:0]         cs;
  logic signed [55:0]         prod;
  logic signed [26:0]         s_reg;
  logic [23:0]                k_reg;
  logic signed [42:0]         tx;
  logic signed [42:0]         ty;
  logic [25:0]                ax;
  logic [25:0]                ay;
  logic                       neg_x;
  logic                       neg_y;
  logic [16:0]                qx;
  logic signed [15:0]         new_x;
  logic signed [15:0]         new_y;

  // Combinational helpers
  logic signed [12:0]         diff;
  logic signed [27:0]         mul_a;
  logic signed [27:0]         mul_b;
  logic signed [55:0]         mul_p;
  logic signed [31:0]         xs;
  logic signed [31:0]         ys;
  logic signed [31:0]         at;
  logic signed [15:0]         c_q;
  logic signed [15:0]         s_q;
  logic [47:0]                k_round;
  logic signed [25:0]         x1000;
  logic signed [25:0]         y1000;
  logic signed [42:0]         x_base;
  logic signed [42:0]         y_base;
  logic signed [42:0]         t_abs;
  logic signed [42:0]         y_new_t;
  logic [23:0]                h_new;

  assign diff  = {right_l[11], right_l} - {left_l[11], left_l};
  assign xs    = cx >>> cmd.iter;
  assign ys    = cy >>> cmd.iter;
  assign at    = atan_angle(cmd.iter);
  assign c_q   = to_q15(cx);
  assign s_q   = to_q15(cy);

  assign k_round = prod[47:0] + 48'd32768;

  // old * 1000 by shift and subtract, then scaled by 2^16
  assign x1000  = (26'(pose_x) <<< 10) - (26'(pose_x) <<< 4) - (26'(pose_x) <<< 3);
  assign y1000  = (26'(pose_y) <<< 10) - (26'(pose_y) <<< 4) - (26'(pose_y) <<< 3);
  assign x_base = {{1{x1000[25]}}, x1000, 16'd0};
  assign y_base = {{1{y1000[25]}}, y1000, 16'd0};
  assign y_new_t = y_base + prod[42:0];

  assign h_new = diff_neg ? (pose_h - k_reg) : (pose_h + k_reg);

  assign status.clear_req = clear_l;

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    t_abs = '0;
    case (cmd.step)
      ddo_pkg::S_ROUND: begin
        mul_a = $signed({14'd0, dur_l});
        mul_b = 28'(sum);
      end
      ddo_pkg::S_MUL_M: begin
        mul_a = $signed({16'd0, absdiff});
        mul_b = $signed({14'd0, dur_l});
      end
      ddo_pkg::S_MUL_K: begin
        // |right - left| * duration comes straight from the previous pass
        mul_a = $signed({2'd0, prod[25:0]});
        mul_b = HEAD_K;
      end
      ddo_pkg::S_MUL_X: begin
        mul_a = 28'(s_reg);
        mul_b = 28'(sn);
      end
      ddo_pkg::S_MUL_Y: begin
        mul_a = 28'(s_reg);
        mul_b = 28'(cs);
      end
      ddo_pkg::S_ABS_X: begin
        t_abs = tx[42] ? -tx : tx;
      end
      ddo_pkg::S_MUL_QX: begin
        mul_a = $signed({2'd0, ax});
        mul_b = RECIP;
        t_abs = ty[42] ? -ty : ty;
      end
      ddo_pkg::S_MUL_QY: begin
        mul_a = $signed({2'd0, ay});
        mul_b = RECIP;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Pose state
  always_ff @(posedge clk) begin
    if (rst) begin
      pose_x <= '0;
      pose_y <= '0;
      pose_h <= '0;
    end else if (cmd.write) begin
      if (clear_l) begin
        pose_x <= '0;
        pose_y <= '0;
        pose_h <= '0;
      end else begin
        pose_x <= new_x;
        pose_y <= new_y;
        pose_h <= h_new;
      end
    end
  end

  // Datapath registers, advanced by the current step
  always_ff @(posedge clk) begin
    prod <= mul_p;
    if (cmd.load) begin
      clear_l <= in_clear;
      left_l  <= $signed(in_data[11:0]);
      right_l <= $signed(in_data[23:12]);
      dur_l   <= in_data[37:24];
    end
    if (cmd.write) begin
      if (clear_l) begin
        out_data <= '0;
      end else begin
        out_data <= {h_new[23:8], new_y, new_x};
      end
    end
    case (cmd.step)
      ddo_pkg::S_PREP: begin
        sum      <= {left_l[11], left_l} + {right_l[11], right_l};
        absdiff  <= diff[12] ? 12'(-diff) : diff[11:0];
        diff_neg <= diff[12];
        cx       <= CORDIC_X0;
        cy       <= '0;
        cz       <= {{2{pose_h[21]}}, pose_h[21:0], 8'd0};
        quad     <= pose_h[23:22] + {1'b0, pose_h[21]};
      end
      ddo_pkg::S_CORDIC: begin
        if (!cz[31]) begin
          cx <= cx - ys;
          cy <= cy + xs;
          cz <= cz - at;
        end else begin
          cx <= cx + ys;
          cy <= cy - xs;
          cz <= cz + at;
        end
      end
      ddo_pkg::S_ROUND: begin
        case (quad)
          2'd0: begin sn <= s_q;  cs <= c_q;  end
          2'd1: begin sn <= c_q;  cs <= -s_q; end
          2'd2: begin sn <= -s_q; cs <= -c_q; end
          default: begin sn <= -c_q; cs <= s_q; end
        endcase
      end
      ddo_pkg::S_MUL_M: s_reg <= prod[26:0];
      ddo_pkg::S_MUL_X: k_reg <= k_round[39:16];
      ddo_pkg::S_MUL_Y: tx    <= x_base - prod[42:0];
      ddo_pkg::S_ABS_X: begin
        ty    <= y_new_t;
        ax    <= t_abs[41:16];
        neg_x <= tx[42];
      end
      ddo_pkg::S_MUL_QX: begin
        ay    <= t_abs[41:16];
        neg_y <= ty[42];
      end
      ddo_pkg::S_MUL_QY: qx <= prod[RECIP_SH+16:RECIP_SH];
      ddo_pkg::S_SAT_X: begin
        new_x <= sat_coord(neg_x, qx);
        new_y <= sat_coord(neg_y, prod[RECIP_SH+16:RECIP_SH]);
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/differential_drive_odometry_unit.sv]
`default_nettype none

// Differential-drive odometry: each input transfer carries two wheel speeds
// (mm/s), an interval (ms) and a clear flag, and returns one result transfer
// with the new pose (x, y in mm saturated at +-32767, heading with 65536 units
// per turn). The move uses the heading from before the item. A regular item
// runs the iterative CORDIC, one micro-rotation per cycle, followed by seven
// passes through one shared 28x28 multiplier, before its result is written;
// the next item is accepted only once that result is written. A clear item
// skips the CORDIC and multiplier steps. A finished result waits in the
// output register while the next item is accepted.
module differential_drive_odometry_unit #(
  parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                s_axis_tvalid,
  output logic                               s_axis_tready,
  // left_speed[11:0], right_speed[23:12], duration_ms[37:24], zero pad
  input  wire  [ddo_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // clear_pose[0]
  input  wire                                s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  // pos_x[15:0], pos_y[31:16], heading[47:32]
  output logic [ddo_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

  ddo_pkg::cmd_t    cmd;
  ddo_pkg::status_t status;

  ddo_ctrl #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .status    (status),
    .cmd       (cmd)
  );

  ddo_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .in_clear (s_axis_tuser),
    .in_data  (s_axis_tdata[ddo_pkg::IN_USED_W-1:0]),
    .out_data (m_axis_tdata)
  );

endmodule

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;

  localparam int     CORDIC_N     = ddo_pkg::CORDIC_STEPS_DEF;
  localparam longint DISP_SCALE   = 65536000;
  localparam longint POS_LIMIT    = 32767;
  localparam longint TURN_GAIN    = 3208521;
  localparam longint CORDIC_GAIN  = 652032874;
  localparam int     DRAIN_CYCLES = 40;

  // Same layout as the result tdata: x in the low bits, heading on top
  typedef struct packed {
    logic [15:0] heading;
    logic [15:0] y;
    logic [15:0] x;
  } pose_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [ddo_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                           s_axis_tuser = 1'b0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [ddo_pkg::OUT_DATA_W-1:0] m_axis_tdata;

  // Arctangent of 2^-i in units of 2^32 per turn
  longint atan_step [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  // Predicted pose
  longint      est_x;
  longint      est_y;
  logic [23:0] est_heading;

  pose_t expected_poses [$];
  int    error_count = 0;

  // Idle control shared by the driver and the receiver
  bit tx_gaps    = 1'b0;
  bit rx_stalls  = 1'b0;
  int hold_cycles = 0;
  int stall_left  = 0;

  differential_drive_odometry_unit uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Idle length: mostly none or short, now and then long
  function automatic int pick_idle();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Round Q2.30 to Q1.15 and clamp
  function automatic longint to_q15(input longint v);
    longint r;
    r = (v + 16384) >>> 15;
    if (r > POS_LIMIT) r = POS_LIMIT;
    if (r < -POS_LIMIT) r = -POS_LIMIT;
    return r;
  endfunction

  // Reduce to nearest quadrant, rotate the residual, then undo the quadrant
  function automatic void heading_sin_cos(input logic [23:0] h, output longint sn,
                                          output longint cs);
    logic [24:0] biased;
    logic [1:0]  quad;
    longint      resid, x, y, z, nx, c, s;
    biased = {1'b0, h} + 25'h200000;
    quad   = biased[23:22];
    resid  = longint'(h) - longint'(quad) * 4194304;
    if (resid >= 8388608) resid -= 16777216;
    z = resid * 256;
    x = CORDIC_GAIN;
    y = 0;
    for (int i = 0; i < CORDIC_N; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - atan_step[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + atan_step[i];
      end
      x = nx;
    end
    c = to_q15(x);
    s = to_q15(y);
    case (quad)
      2'd0: begin sn = s;  cs = c;  end
      2'd1: begin sn = c;  cs = -s; end
      2'd2: begin sn = -s; cs = -c; end
      default: begin sn = -c; cs = s; end
    endcase
  endfunction

  // Exact displacement, truncate toward zero, clamp
  function automatic longint move_coord(input longint old, input longint disp);
    longint v;
    v = (old * DISP_SCALE + disp) / DISP_SCALE;
    if (v > POS_LIMIT) v = POS_LIMIT;
    if (v < -POS_LIMIT) v = -POS_LIMIT;
    return v;
  endfunction

  // Advance the predicted pose by one transfer and return the new pose
  function automatic pose_t advance_pose(input logic clear, input logic signed [11:0] left,
                                         input logic signed [11:0] right,
                                         input logic [13:0] dur);
    longint l, r, d, travel, sn, cs, diff, m, k;
    pose_t  p;
    if (clear) begin
      est_x       = 0;
      est_y       = 0;
      est_heading = '0;
    end else begin
      l      = left;
      r      = right;
      d      = dur;
      travel = d * (l + r);
      heading_sin_cos(est_heading, sn, cs);
      est_x  = move_coord(est_x, -(travel * sn));
      est_y  = move_coord(est_y, travel * cs);
      diff   = r - l;
      m      = (diff < 0 ? -diff : diff) * d;
      k      = ((m * TURN_GAIN + 32768) >>> 16) & 64'hFFFFFF;
      if (diff >= 0) est_heading = est_heading + k[23:0];
      else           est_heading = est_heading - k[23:0];
    end
    p.x       = est_x[15:0];
    p.y       = est_y[15:0];
    p.heading = est_heading[23:8];
    return p;
  endfunction

  // Offer one item, wait for its transfer, record the predicted pose.
  // Valid stays high on return so a following item can go back to back.
  task automatic send_odometry(input logic clear, input logic signed [11:0] left,
                               input logic signed [11:0] right, input logic [13:0] dur);
    int gap;
    gap = tx_gaps ? pick_idle() : 0;
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tdata  = {2'b00, dur, right, left};
    s_axis_tuser  = clear;
    s_axis_tvalid = 1'b1;
    forever begin
      @(posedge clk);
      if (s_axis_tready) break;
    end
    expected_poses.push_back(advance_pose(clear, left, right, dur));
    @(negedge clk);
  endtask

  // Drop valid and wait until every predicted pose has come back
  task automatic wait_all_results();
    s_axis_tvalid = 1'b0;
    while (expected_poses.size() != 0) @(negedge clk);
  endtask

  task automatic send_random_item();
    logic        clear;
    logic [11:0] left, right;
    logic [13:0] dur;
    int          roll;
    clear = ($urandom_range(0, 99) < 3);
    left  = 12'($urandom);
    right = 12'($urandom);
    roll  = $urandom_range(0, 99);
    // Straight runs and turns on the spot
    if (roll < 15) right = left;
    else if (roll < 25) right = -left;
    else if (roll < 45) begin
      left  = 12'(int'($urandom_range(0, 600)) - 300);
      right = 12'(int'($urandom_range(0, 600)) - 300);
    end
    roll = $urandom_range(0, 9);
    if (roll < 6) dur = 14'($urandom_range(0, 255));
    else if (roll < 9) dur = 14'($urandom_range(0, 10000));
    else dur = 14'($urandom_range(10001, 16383));
    send_odometry(clear, left, right, dur);
  endtask

  // Field extremes, clears with live speeds, zero interval
  task automatic test_extremes();
    send_odometry(1'b1, 12'sd0, 12'sd0, 14'd0);
    send_odometry(1'b0, 12'sd2047, 12'sd2047, 14'd16383);
    send_odometry(1'b0, -12'sd2048, -12'sd2048, 14'd16383);
    send_odometry(1'b1, 12'sd2047, -12'sd2048, 14'd16383);
    send_odometry(1'b0, -12'sd2048, 12'sd2047, 14'd16383);
    send_odometry(1'b0, 12'sd2047, -12'sd2048, 14'd10000);
    send_odometry(1'b0, 12'sd0, 12'sd0, 14'd0);
    send_odometry(1'b0, 12'sd1, -12'sd1, 14'd1);
    send_odometry(1'b0, -12'sd1, 12'sd1, 14'd10000);
    send_odometry(1'b0, 12'sd1000, 12'sd1000, 14'd0);
    wait_all_results();
  endtask

  // Step through all four quadrants and their boundaries, both turn senses
  task automatic test_quadrants();
    send_odometry(1'b1, 12'sd0, 12'sd0, 14'd0);
    repeat (4) begin
      send_odometry(1'b0, -12'sd1000, 12'sd1000, 14'd43);
      send_odometry(1'b0, 12'sd500, 12'sd500, 14'd1000);
    end
    send_odometry(1'b0, -12'sd1000, 12'sd1000, 14'd43);
    send_odometry(1'b0, 12'sd2047, 12'sd2047, 14'd16383);
    repeat (2) begin
      send_odometry(1'b0, 12'sd1000, -12'sd1000, 14'd43);
      send_odometry(1'b0, 12'sd700, 12'sd300, 14'd900);
    end
    wait_all_results();
  endtask

  // Hold the receiver off long enough that the input stalls behind it
  task automatic test_backpressure();
    tx_gaps   = 1'b0;
    rx_stalls = 1'b0;
    hold_cycles = 400;
    repeat (10) send_random_item();
    wait_all_results();
  endtask

  // Random traffic in chunks, idling on and off, draining now and then
  task automatic test_random(input int chunks);
    for (int c = 0; c < chunks; c++) begin
      tx_gaps   = (c % 3) != 0;
      rx_stalls = (c % 4) != 1;
      repeat (100) send_random_item();
      if (c % 4 == 3) wait_all_results();
    end
    wait_all_results();
  endtask

  // Receiver: long hold-offs first, then random stalls
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      m_axis_tready = 1'b0;
      hold_cycles   = hold_cycles - 1;
    end else if (stall_left > 0) begin
      m_axis_tready = 1'b0;
      stall_left    = stall_left - 1;
    end else begin
      m_axis_tready = 1'b1;
      if (rx_stalls) stall_left = pick_idle();
    end
  end

  // Compare each result transfer with the oldest predicted pose
  always @(posedge clk) begin
    pose_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (expected_poses.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d heading=%0d", $time,
                 $signed(got.x), $signed(got.y), got.heading);
        error_count++;
      end else begin
        want = expected_poses.pop_front();
        if (got.x !== want.x) begin
          $display("%0t: pos_x expected %0d got %0d", $time, $signed(want.x), $signed(got.x));
          error_count++;
        end
        if (got.y !== want.y) begin
          $display("%0t: pos_y expected %0d got %0d", $time, $signed(want.y), $signed(got.y));
          error_count++;
        end
        if (got.heading !== want.heading) begin
          $display("%0t: heading expected %0d got %0d", $time, want.heading, got.heading);
          error_count++;
        end
      end
    end
  end

  initial begin
    est_x       = 0;
    est_y       = 0;
    est_heading = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_extremes();
    test_quadrants();
    test_backpressure();
    test_random(13);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Give up if the run hangs
  initial begin
    #10_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
